// ----- design/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CLBR_ASSERT_IMP(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// next-cycle implication, disabled during reset
`define CLBR_ASSERT_NXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ----- design/clbr_pkg.sv -----
package clbr_pkg;

  localparam int COLS    = 8;
  localparam int ROWS    = 2;
  localparam int CELLS   = COLS * ROWS;
  localparam int POS_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PAINT_W = $clog2(CELLS + 1);
  localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_SETPOS = 2'd2;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HOME   = 2'd1;
  localparam logic [1:0] PH_ROWCHK = 2'd2;
  localparam logic [1:0] PH_DATA   = 2'd3;

  localparam logic [7:0] CMD_DDRAM = 8'h80;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [3:0] column;
    logic [1:0] row;
  } item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] lcd_byte;
  } result_t;

  // store side controls for one processed item
  typedef struct packed {
    logic       wr;
    logic       set;
    logic [7:0] char_code;
    logic [3:0] column;
    logic [1:0] row;
  } store_ctl_t;

  // painter output for one processed item
  typedef struct packed {
    logic    emit;
    result_t beat;
  } paint_res_t;

  function automatic logic [7:0] row_offset(input logic [1:0] r);
    logic [7:0] off;
    case (r)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h14;
      default: off = 8'h54;
    endcase
    return off;
  endfunction

endpackage

// ----- design/clbr_store.sv -----
module clbr_store import clbr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  store_ctl_t       ctl,
  input  logic [POS_W-1:0] rd_idx,
  output logic [7:0]       rd_data
);

  logic [7:0]       char_store [CELLS];
  logic [POS_W-1:0] write_pos;
  logic [POS_W-1:0] write_pos_next;
  logic [5:0]       set_pos;
  logic             set_ok;

  assign set_pos = 6'(ctl.column) + 6'(ctl.row) * 6'(COLS);
  assign set_ok  = (ctl.column < COLS) && (ctl.row < ROWS);

  always_comb begin
    write_pos_next = write_pos;
    if (ctl.wr) begin
      if (write_pos == POS_W'(CELLS - 1)) begin
        write_pos_next = '0;
      end else begin
        write_pos_next = write_pos + POS_W'(1);
      end
    end else if (ctl.set && set_ok) begin
      write_pos_next = POS_W'(set_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= '0;
      for (int i = 0; i < CELLS; i++) begin
        char_store[POS_W'(i)] <= 8'h00;
      end
    end else begin
      write_pos <= write_pos_next;
      if (ctl.wr) begin
        char_store[write_pos] <= ctl.char_code;
      end
    end
  end

  assign rd_data = char_store[rd_idx];

endmodule

// ----- design/clbr_painter.sv -----
module clbr_painter import clbr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             tick,
  input  logic             set_pending,
  input  logic [7:0]       store_byte,
  output logic [POS_W-1:0] paint_idx,
  output paint_res_t       res
);

  logic [1:0]         phase;
  logic [1:0]         phase_next;
  logic [PAINT_W-1:0] paint_pos;
  logic [PAINT_W-1:0] paint_pos_next;
  logic [COL_W-1:0]   paint_col;
  logic [COL_W-1:0]   paint_col_next;
  logic [ROW_W-1:0]   paint_row;
  logic [ROW_W-1:0]   paint_row_next;
  logic               refresh_pending;
  logic               pending_clr;
  logic [PAINT_W-1:0] pos_inc;

  assign paint_idx = paint_pos[POS_W-1:0];
  assign pos_inc   = paint_pos + PAINT_W'(1);

  always_comb begin
    phase_next     = phase;
    paint_pos_next = paint_pos;
    paint_col_next = paint_col;
    paint_row_next = paint_row;
    pending_clr    = 1'b0;
    res            = '0;
    case (phase)
      PH_IDLE: begin
        if (refresh_pending) begin
          pending_clr = 1'b1;
          phase_next  = PH_HOME;
        end
      end
      PH_HOME: begin
        paint_pos_next    = '0;
        paint_col_next    = '0;
        paint_row_next    = '0;
        res.emit          = 1'b1;
        res.beat.is_data  = 1'b0;
        res.beat.lcd_byte = CMD_DDRAM;
        phase_next        = PH_ROWCHK;
      end
      PH_ROWCHK: begin
        if (paint_pos < CELLS && paint_col == '0) begin
          res.emit          = 1'b1;
          res.beat.is_data  = 1'b0;
          res.beat.lcd_byte = CMD_DDRAM + row_offset(2'(paint_row));
        end
        phase_next = PH_DATA;
      end
      default: begin
        if (paint_pos < CELLS) begin
          res.emit          = 1'b1;
          res.beat.is_data  = 1'b1;
          res.beat.lcd_byte = store_byte;
          paint_pos_next    = pos_inc;
          if (paint_col == COL_W'(COLS - 1)) begin
            paint_col_next = '0;
            paint_row_next = paint_row + ROW_W'(1);
          end else begin
            paint_col_next = paint_col + COL_W'(1);
          end
        end
        phase_next = (paint_pos_next >= CELLS) ? PH_IDLE : PH_ROWCHK;
      end
    endcase
    if (!tick) begin
      res.emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      paint_pos       <= '0;
      paint_col       <= '0;
      paint_row       <= '0;
      refresh_pending <= 1'b0;
    end else begin
      if (tick) begin
        phase     <= phase_next;
        paint_pos <= paint_pos_next;
        paint_col <= paint_col_next;
        paint_row <= paint_row_next;
      end
      if (set_pending) begin
        refresh_pending <= 1'b1;
      end else if (tick && pending_clr) begin
        refresh_pending <= 1'b0;
      end
    end
  end

endmodule

// ----- design/char_lcd_buffer_refresh.sv -----
// flow: an accepted beat is held in the item register, and any result beat it makes is loaded into the result register
// throughput: one item per cycle while the result register is free or being drained, set by the
// single processing stage between the item register and the result register
// reset: rst is synchronous, active high; clears the character buffer, write
// position, painter phase and position, refresh flag and both valid flags
`include "assert_macros.svh"

module char_lcd_buffer_refresh import clbr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  // item register: holds one accepted beat until the processing stage takes it
  item_t            item_q;
  logic             item_q_valid;
  logic             advance;
  logic             accept;

  store_ctl_t       store_ctl;
  logic [POS_W-1:0] paint_idx;
  logic [7:0]       store_byte;
  paint_res_t       paint_res;
  logic             tick;

  // process the held beat when the result register is free or being drained
  assign advance    = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || advance;
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (accept) begin
      item_q_valid <= 1'b1;
    end else if (advance) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
  end

  // decode of the held beat; operation 3 does nothing at all
  assign tick                = advance && (item_q.operation == OP_TICK);
  assign store_ctl.wr        = advance && (item_q.operation == OP_WRITE);
  assign store_ctl.set       = advance && (item_q.operation == OP_SETPOS);
  assign store_ctl.char_code = item_q.char_code;
  assign store_ctl.column    = item_q.column;
  assign store_ctl.row       = item_q.row;

  // character buffer and write position
  clbr_store u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (store_ctl),
    .rd_idx  (paint_idx),
    .rd_data (store_byte)
  );

  // repaint sequencer; every write requests a repaint
  clbr_painter u_painter (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick),
    .set_pending (store_ctl.wr),
    .store_byte  (store_byte),
    .paint_idx   (paint_idx),
    .res         (paint_res)
  );

  // result register: loads only when a tick produced a byte
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= paint_res.emit;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && paint_res.emit) begin
      result <= paint_res.beat;
    end
  end

  // a waiting result beat must block the processing stage
  `CLBR_ASSERT_IMP(a_no_overwrite, clk, rst, result_valid && !result_ready, !advance, "result overwritten")
  // a held beat that cannot move blocks new beats
  `CLBR_ASSERT_IMP(a_hold_blocks, clk, rst, item_q_valid && !advance, !item_ready, "item register overrun")
  // write and set-position beats never create a result
  `CLBR_ASSERT_NXT(a_no_spurious, clk, rst, advance && item_q.operation != OP_TICK, result_valid == 1'b0, "non-tick result")

endmodule
